@@ rtl/multicolour_sprite_dither_pack_unit_defines.svh @@
// Assertion macros for the sprite dither packer.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef MULTICOLOUR_SPRITE_DITHER_PACK_UNIT_DEFINES_SVH
`define MULTICOLOUR_SPRITE_DITHER_PACK_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define MSDP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define MSDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/msdp_pkg.sv @@
// Shared types, constants and helpers for the sprite dither packer.
// No dependencies.
`default_nettype none

package msdp_pkg;

  localparam int IMG_WIDTH         = 24;
  localparam int IMG_HEIGHT        = 42;
  localparam int SPRITE_LINES      = 21;
  localparam int GROUPS_PER_SPRITE = 3;
  localparam int BAND_COUNT        = 8;
  localparam int THR_W             = 12;   // offset + 8*step tops out at 2295
  localparam int SUM_W             = 10;   // r+g+b tops out at 765
  localparam int PROD_W            = 19;   // 765*683 fits in 19 bits
  localparam int DIV3_SHIFT        = 11;
  localparam logic [SUM_W-1:0] DIV3_RECIP = 10'd683;  // ceil(2048/3)

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    REG_GREY_OFFSET = 1'b0,
    REG_BAND_STEP   = 1'b1
  } reg_index_t;

  localparam logic [7:0] GREY_OFFSET_RESET = 8'd0;
  localparam logic [7:0] BAND_STEP_RESET   = 8'd25;

  localparam logic [2:0] BLACK_LEVEL = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] column;
    logic [5:0] line;
  } pixel_t;

  typedef struct packed {
    logic [7:0] colour_byte;
    logic [7:0] outline_byte;
    logic [1:0] sprite_number;
    logic [5:0] byte_index;
  } result_t;

  // Grey value with its position, handed from the grey stage to the pack stage.
  typedef struct packed {
    logic [7:0] grey;
    logic [4:0] column;
    logic [5:0] line;
  } grey_item_t;

  typedef logic [BAND_COUNT-1:0][THR_W-1:0] thr_array_t;

  // Load and advance strobes for the pipeline registers.
  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s2_fire;
    logic out_load;
  } stage_ctl_t;

  // Level 0..4 from band count k (0..8); 4 is black. Odd bands dither:
  // matching parity takes the darker neighbor.
  function automatic logic [2:0] level_of(input logic [3:0] k, input logic same_parity);
    logic [2:0] half;
    half = k[3:1];
    if (k[0] && !same_parity) begin
      level_of = 3'd3 - half;
    end else begin
      level_of = 3'd4 - half;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/msdp_cfg.sv @@
// Configuration registers and band threshold table for the sprite dither packer.
// Depends on msdp_pkg.
`default_nettype none

module msdp_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [msdp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [msdp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [msdp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output msdp_pkg::thr_array_t                 thr
);
  import msdp_pkg::*;

  logic [7:0] grey_offset;
  logic [7:0] band_step;
  reg_index_t index;
  logic       wr_en;

  assign pready = 1'b1;
  assign index  = reg_index_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grey_offset <= GREY_OFFSET_RESET;
      band_step   <= BAND_STEP_RESET;
    end else if (wr_en) begin
      case (index)
        REG_GREY_OFFSET: grey_offset <= pwdata[7:0];
        REG_BAND_STEP:   band_step   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_GREY_OFFSET: prdata = {{(CFG_DATA_W-8){1'b0}}, grey_offset};
      REG_BAND_STEP:   prdata = {{(CFG_DATA_W-8){1'b0}}, band_step};
      default:         prdata = '0;
    endcase
  end

  // Registered full-precision thresholds offset + step*(i+1).
  always_ff @(posedge clk) begin
    for (int i = 0; i < BAND_COUNT; i++) begin
      thr[i] <= THR_W'(grey_offset) + THR_W'(band_step) * THR_W'(i + 1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/msdp_grey.sv @@
// Input register and grey conversion (divide-by-3 via reciprocal multiply).
// Depends on msdp_pkg.
`default_nettype none

module msdp_grey (
  input  wire logic                 clk,
  input  wire msdp_pkg::stage_ctl_t ctl,
  input  wire msdp_pkg::pixel_t     pixel,
  output msdp_pkg::grey_item_t      item
);
  import msdp_pkg::*;

  pixel_t            s1_pix;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1_pix <= pixel;
    end
  end

  assign sum  = SUM_W'(s1_pix.red) + SUM_W'(s1_pix.green) + SUM_W'(s1_pix.blue);
  // Widen both operands first so the product keeps all of its bits.
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_RECIP);

  assign item.grey   = prod[DIV3_SHIFT +: 8];
  assign item.column = s1_pix.column;
  assign item.line   = s1_pix.line;

endmodule

`default_nettype wire

@@ rtl/msdp_pack.sv @@
// Band classification, checkerboard dither, group accumulation and result register.
// Depends on msdp_pkg.
`default_nettype none

module msdp_pack (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire msdp_pkg::stage_ctl_t ctl,
  input  wire msdp_pkg::grey_item_t item,
  input  wire msdp_pkg::thr_array_t thr,
  output logic                      emit,
  output msdp_pkg::result_t         result
);
  import msdp_pkg::*;

  grey_item_t s2;
  logic [7:0] colour_accum;
  logic [7:0] outline_accum;
  logic [7:0] colour_next;
  logic [7:0] outline_next;
  logic [7:0] colour_base;
  logic [7:0] outline_base;
  logic [7:0] field_mask;
  logic [2:0] shift;
  logic [1:0] pos;
  logic       in_range;
  logic       run;
  logic [3:0] k;
  logic [2:0] level;
  logic       black;
  logic [2:0] group;
  logic       right_half;
  logic       lower_half;
  logic [4:0] row_mod;
  logic [1:0] group_mod;
  result_t    res_next;

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      s2 <= item;
    end
  end

  assign in_range = (s2.column < 5'(IMG_WIDTH)) && (s2.line < 6'(IMG_HEIGHT));
  assign pos      = s2.column[1:0];
  assign emit     = in_range && (pos == 2'd3);

  // Count thresholds reached, stopping at the first miss.
  always_comb begin
    run = 1'b1;
    k   = '0;
    for (int i = 0; i < BAND_COUNT; i++) begin
      run = run && ({4'b0, s2.grey} >= thr[i]);
      if (run) begin
        k = 4'(i + 1);
      end
    end
  end

  assign level = level_of(k, s2.column[0] == s2.line[0]);
  assign black = (level == BLACK_LEVEL);

  assign shift        = {~pos, 1'b0};
  assign field_mask   = 8'b11 << shift;
  assign colour_base  = (pos == 2'd0) ? 8'd0 : colour_accum;
  assign outline_base = (pos == 2'd0) ? 8'd0 : outline_accum;

  assign colour_next  = (colour_base & ~field_mask)
                      | (black ? 8'd0 : ({6'd0, level[1:0]} << shift));
  assign outline_next = black ? (outline_base | field_mask) : outline_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_accum  <= '0;
      outline_accum <= '0;
    end else if (ctl.s2_fire && in_range) begin
      colour_accum  <= colour_next;
      outline_accum <= outline_next;
    end
  end

  assign group      = s2.column[4:2];
  assign right_half = (group >= 3'(GROUPS_PER_SPRITE));
  assign lower_half = (s2.line >= 6'(SPRITE_LINES));
  assign row_mod    = lower_half ? 5'(s2.line - 6'(SPRITE_LINES)) : s2.line[4:0];
  assign group_mod  = right_half ? 2'(group - 3'(GROUPS_PER_SPRITE)) : group[1:0];

  assign res_next.colour_byte   = colour_next;
  assign res_next.outline_byte  = outline_next;
  assign res_next.sprite_number = {lower_half, right_half};
  assign res_next.byte_index    = {row_mod, 1'b0} + {1'b0, row_mod} + {4'd0, group_mod};

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/multicolour_sprite_dither_pack_unit.sv @@
// Sprite dither packer top level: pipeline control, config port and assertions.
// Depends on msdp_pkg, msdp_cfg, msdp_grey, msdp_pack and the defines header.
`default_nettype none

// Takes one RGB pixel per cycle of a 24x42 image unless stalled, reduces it to
// grey, places it in one of nine bands set by grey_offset and band_step (odd
// bands dither on a 2x2 checkerboard) and packs four pixels into a colour byte
// and an outline byte. The fourth pixel of each group produces one result beat
// carrying both bytes, the sprite number and the byte index inside that 63-byte
// sprite; other pixels produce none, and pixels outside the image are dropped
// without touching the group state. Sustained rate is one pixel per clock while
// result_stall is low; the path is three registers deep (input register, grey
// register, result register). The result register and the grey register
// decouple the two sides, so pixels that produce no result keep flowing while a
// finished result waits to be taken. Threshold values are registered from
// grey_offset and band_step and follow each register write.
// Register map (APB, 32-bit): 0x0 grey_offset, 0x4 band_step.

module multicolour_sprite_dither_pack_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pixel_valid,
  output logic                                 pixel_stall,
  input  wire msdp_pkg::pixel_t                pixel,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output msdp_pkg::result_t                    result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [msdp_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [msdp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [msdp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import msdp_pkg::*;

  `include "multicolour_sprite_dither_pack_unit_defines.svh"

  thr_array_t thr;
  grey_item_t grey_item;
  stage_ctl_t ctl;

  logic s1_valid;
  logic s2_valid;
  logic s2_emit;
  logic out_free;
  logic s2_free;
  logic s1_free;

  // Config registers and threshold table.
  msdp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // Stage 1: input register, grey conversion.
  msdp_grey u_grey (
    .clk   (clk),
    .ctl   (ctl),
    .pixel (pixel),
    .item  (grey_item)
  );

  // Stage 2: classify, dither, accumulate; result register.
  msdp_pack u_pack (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (grey_item),
    .thr    (thr),
    .emit   (s2_emit),
    .result (result)
  );

  // Result register frees up when empty or when its beat is taken.
  assign out_free = !result_valid || !result_stall;
  // Stage 2 retires unless it must emit and the result register is blocked.
  assign ctl.s2_fire  = s2_valid && (!s2_emit || out_free);
  assign ctl.out_load = ctl.s2_fire && s2_emit;
  assign s2_free      = !s2_valid || ctl.s2_fire;
  // Advance stage 1 into stage 2 whenever stage 2 has room.
  assign ctl.s2_load  = s1_valid && s2_free;
  assign s1_free      = !s1_valid || ctl.s2_load;
  // Accept a new pixel whenever stage 1 has room.
  assign pixel_stall  = !s1_free;
  assign ctl.s1_load  = pixel_valid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.s1_load) begin
        s1_valid <= 1'b1;
      end else if (ctl.s2_load) begin
        s1_valid <= 1'b0;
      end

      if (ctl.s2_load) begin
        s2_valid <= 1'b1;
      end else if (ctl.s2_fire) begin
        s2_valid <= 1'b0;
      end

      if (ctl.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Input backs up only when both pipeline stages hold an item.
  `MSDP_ASSERT_NOW(a_stall_full, pixel_stall, s1_valid && s2_valid, "input stalled with room in pipe")
  // A new result comes only from a stage 2 item.
  `MSDP_ASSERT_NOW(a_rise_src, $rose(result_valid), $past(s2_valid), "result without a stage 2 item")
  // A group end with a free result register lands in the result register.
  `MSDP_ASSERT_NEXT(a_emit_load, s2_valid && s2_emit && out_free, result_valid, "emitted group lost")
  // Byte index stays inside the 63-byte sprite.
  `MSDP_ASSERT_NOW(a_index_range, result_valid, result.byte_index <= 6'd62, "byte index out of sprite")

endmodule

`default_nettype wire
